// File: rtl/mrs_pkg.sv
`timescale 1ns / 1ps

package mrs_pkg;

  // Field and register widths.
  localparam int IDX_W            = 6;
  localparam int NC_W             = 7;
  localparam int DATA_W           = 32;
  localparam int MAX_CLUSTERS_DEF = 64;

  // Running sums of up to 64 values of at most 2^31 each, plus margin.
  localparam int SUM_W = 39;

  // Shared signed multiplier operand width.
  localparam int MUL_W = 34;

  // ln(2) in Q0.32 and the number of Taylor terms of the exponential.
  localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_NUM_CLUSTERS    = 1'b0,
    CFG_NOISE_PRECISION = 1'b1
  } cfg_reg_e;

  // Input item kinds.
  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SC_RD, ST_SC_MU, ST_SC_PG, ST_SC_MAG, ST_SC_PP, ST_SC_ACC, ST_SC_WR,
    ST_EX_RD, ST_EX_DX, ST_EX_K, ST_EX_T1, ST_EX_T2, ST_EX_T3, ST_EX_WR,
    ST_N1_RD, ST_N1_GO, ST_N1_WT, ST_N1_WR,
    ST_N2_RD, ST_N2_GO, ST_N2_WT, ST_N2_OUT
  } st_e;

  // One cluster entry of the parameter memory.
  typedef struct packed {
    logic signed [31:0] lead;
    logic        [31:0] ginv;
    logic signed [31:0] mu;
    logic        [31:0] musq;
  } param_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [63:0]      dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor((2^32 - 1) / n): reciprocal for the Taylor term division.
  function automatic logic [31:0] recip_q32(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h7FFF_FFFF;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h3FFF_FFFF;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h1FFF_FFFF;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/mrs_ram.sv
`timescale 1ns / 1ps

module mrs_ram #(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/mrs_div.sv
`timescale 1ns / 1ps

module mrs_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrs_pkg::div_req_t req_i,
  output mrs_pkg::div_rsp_t rsp_o
);

  import mrs_pkg::*;

  logic [SUM_W-1:0] rem_q, dvs_q;
  logic [31:0]      lo_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [SUM_W:0]   trial;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The upper half of the
  // dividend is below the divisor, so 32 quotient bits are enough.
  assign trial = {rem_q, lo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= SUM_W'(req_i.dividend[63:32]);
      lo_q  <= req_i.dividend[31:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? SUM_W'(trial - {1'b0, dvs_q}) : trial[SUM_W-1:0];
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = lo_q;

endmodule

// File: rtl/mixture_responsibility_softmax.sv
`timescale 1ns / 1ps

// Gaussian mixture membership probabilities. A load beat (kind 0) writes one
// cluster's parameters into the parameter memory as it is accepted. A sample
// beat (kind 1) scores every cluster in use, takes a softmax with a floor of
// one LSB and a renormalize, and delivers one result beat per cluster, the
// last one flagged; the input stalls until the last beat is issued. Each
// cluster passes once through scoring (on the shared 34x34 multiplier), once
// through the exponential (a range reduction and 12 Taylor terms, each through
// states T1, T2 and T3; an underflow skips the terms) and twice through the
// 32-step radix-2 divider.
// Cluster state and the per-cluster scratch values sit in two single-write,
// registered-read memories; no clearing pass is needed.
module mixture_responsibility_softmax #(
  parameter int MAX_CLUSTERS = mrs_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [5:0]          cluster_index_i,
  input  logic signed [31:0]  log_nu_i,
  input  logic signed [31:0]  log_one_minus_nu_i,
  input  logic signed [31:0]  log_gamma_sq_i,
  input  logic [31:0]         gamma_sq_inv_i,
  input  logic signed [31:0]  mu_i,
  input  logic [31:0]         mu_sq_i,
  input  logic signed [31:0]  sample_i,
  input  logic [31:0]         sample_sq_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          result_cluster_o,
  output logic [31:0]         probability_o,
  output logic                last_o
);

  import mrs_pkg::*;

  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam logic [NC_W-1:0] MAX_NC = NC_W'(MAX_CLUSTERS);

  // Control state.
  st_e                st_q, st_d;
  logic [NC_W-1:0]    nc_q;
  logic [31:0]        np_q;
  logic signed [31:0] stick_q;
  logic [AW-1:0]      h_q;
  logic [1:0]         pp_q;
  logic [2:0]         kb_q;
  logic [3:0]         tn_q;
  logic               out_valid_q;

  // Datapath registers.
  logic signed [31:0]       s_q, mx_q;
  logic [31:0]              ssq_q, v_q, p_q;
  param_t                   prm_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_q;
  logic signed [49:0]       d_q;
  logic [47:0]              pg_q, x_q;
  logic [48:0]              mag_q;
  logic [96:0]              acc_q;
  logic [4:0]               k_q;
  logic                     z_q;
  logic [32:0]              t_q;
  logic signed [35:0]       sum_q;
  logic [SUM_W-1:0]         tot_q, tot2_q;
  logic [5:0]               out_cluster_q;
  logic [31:0]              out_prob_q;
  logic                     out_last_q;

  // Memory ports.
  logic          prm_we;
  logic [AW-1:0] prm_waddr, prm_raddr;
  param_t        prm_wdata, prm_rdata;
  logic          scr_we;
  logic [31:0]   scr_wdata, scr_rdata;
  logic [AW-1:0] scr_raddr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Accepted beats.
  logic in_acc, load_acc, samp_acc, out_load;
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (kind_e'(kind_i) == KIND_LOAD);
  assign samp_acc   = in_acc && (kind_e'(kind_i) == KIND_SAMPLE);

  // Clusters in use, clipped to one through MAX_CLUSTERS.
  logic [NC_W-1:0] n_eff, n_m1;
  logic [AW-1:0]   nlast;
  logic            h_end;
  always_comb begin
    if (nc_q == '0) begin
      n_eff = NC_W'(1);
    end else if (nc_q > MAX_NC) begin
      n_eff = MAX_NC;
    end else begin
      n_eff = nc_q;
    end
    n_m1  = n_eff - NC_W'(1);
    nlast = n_m1[AW-1:0];
  end
  assign h_end = (h_q == nlast);

  // Load path: leading term and running stick sum.
  logic signed [31:0] stick_use, lead_new, stick_new;
  assign stick_use = (cluster_index_i == '0) ? 32'sd0 : stick_q;
  assign lead_new  = sat32(48'(log_nu_i) + 48'(stick_use) - 48'(log_gamma_sq_i));
  assign stick_new = sat32(48'(stick_use) + 48'(log_one_minus_nu_i));

  // Distance and penalty terms.
  logic signed [49:0] d_new;
  logic [63:0]        pp_prod;
  logic [96:0]        pp_add;
  logic [1:0]         pp_prev;
  logic               pen_sat;
  logic [40:0]        pen_mag;
  logic signed [41:0] pen;
  logic signed [31:0] score;
  assign d_new = $signed({18'b0, ssq_q}) + $signed({18'b0, prm_q.musq})
               - 50'($signed(mul_q[63:15]));
  assign pp_prod = mul_q[63:0];
  assign pp_prev = (st_q == ST_SC_ACC) ? 2'd3 : pp_q - 2'd1;
  always_comb begin
    unique case (pp_prev)
      2'd0:    pp_add = 97'(pp_prod);
      2'd1,
      2'd2:    pp_add = 97'(pp_prod) << 32;
      default: pp_add = 97'(pp_prod) << 64;
    endcase
  end
  assign pen_sat = acc_q > (97'd1 << 57);
  assign pen_mag = pen_sat ? (41'd1 << 40) : acc_q[57:17];
  assign pen     = d_q[49] ? -$signed({1'b0, pen_mag}) : $signed({1'b0, pen_mag});
  assign score   = sat32(48'(prm_q.lead) - 48'(pen));

  // Exponential terms.
  logic signed [32:0] dx;
  logic [47:0]        ln2_sh;
  logic               k_ge;
  logic [31:0]        q0, tq;
  logic [35:0]        trem;
  logic [34:0]        sum_pos;
  logic [31:0]        e_val;
  logic [SUM_W-1:0]   tot_new, tot2_new;
  assign dx      = $signed({mx_q[31], mx_q}) - $signed({scr_rdata[31], scr_rdata});
  assign ln2_sh  = 48'(LN2_Q32) << kb_q;
  assign k_ge    = x_q >= ln2_sh;
  assign q0      = mul_q[63:32];
  assign trem    = 36'(v_q) - 36'(q0) * 36'(tn_q);
  assign tq      = q0 + ((trem >= 36'(tn_q)) ? 32'd1 : 32'd0);
  assign sum_pos = sum_q[35] ? '0 : sum_q[34:0];
  assign e_val   = z_q ? 32'd0 : 32'(sum_pos >> ({1'b0, k_q} + 6'd1));
  assign tot_new  = tot_q + SUM_W'(e_val);
  assign tot2_new = tot2_q + SUM_W'(p_q);

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (samp_acc) st_d = ST_SC_RD;
      ST_SC_RD:  st_d = ST_SC_MU;
      ST_SC_MU:  st_d = ST_SC_PG;
      ST_SC_PG:  st_d = ST_SC_MAG;
      ST_SC_MAG: st_d = ST_SC_PP;
      ST_SC_PP:  if (pp_q == 2'd3) st_d = ST_SC_ACC;
      ST_SC_ACC: st_d = ST_SC_WR;
      ST_SC_WR:  st_d = h_end ? ST_EX_RD : ST_SC_RD;
      ST_EX_RD:  st_d = ST_EX_DX;
      ST_EX_DX:  st_d = ST_EX_K;
      ST_EX_K: begin
        if (kb_q == 3'd5 && k_ge) begin
          st_d = ST_EX_WR;
        end else if (kb_q == 3'd0) begin
          st_d = ST_EX_T1;
        end
      end
      ST_EX_T1:  st_d = ST_EX_T2;
      ST_EX_T2:  st_d = ST_EX_T3;
      ST_EX_T3:  st_d = (tn_q == TAYLOR_TERMS) ? ST_EX_WR : ST_EX_T1;
      ST_EX_WR:  st_d = h_end ? ST_N1_RD : ST_EX_RD;
      ST_N1_RD:  st_d = ST_N1_GO;
      ST_N1_GO:  st_d = ST_N1_WT;
      ST_N1_WT:  if (div_rsp.done) st_d = ST_N1_WR;
      ST_N1_WR:  st_d = h_end ? ST_N2_RD : ST_N1_RD;
      ST_N2_RD:  st_d = ST_N2_GO;
      ST_N2_GO:  st_d = ST_N2_WT;
      ST_N2_WT:  if (div_rsp.done) st_d = ST_N2_OUT;
      ST_N2_OUT: if (out_load) st_d = h_end ? ST_IDLE : ST_N2_RD;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Memory, multiplier and divider controls.
  always_comb begin
    prm_raddr        = h_q;
    scr_raddr        = h_q;
    scr_we           = 1'b0;
    scr_wdata        = p_q;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, scr_rdata, 31'b0};
    div_req.divisor  = tot_q;
    out_load         = 1'b0;
    unique case (st_q)
      ST_SC_MU: begin
        mul_a = MUL_W'(s_q);
        mul_b = MUL_W'(prm_rdata.mu);
      end
      ST_SC_PG: begin
        mul_a = $signed({2'b0, np_q});
        mul_b = $signed({2'b0, prm_q.ginv});
      end
      ST_SC_PP: begin
        unique case (pp_q)
          2'd0: begin
            mul_a = $signed({2'b0, pg_q[31:0]});
            mul_b = $signed({2'b0, mag_q[31:0]});
          end
          2'd1: begin
            mul_a = $signed({18'b0, pg_q[47:32]});
            mul_b = $signed({2'b0, mag_q[31:0]});
          end
          2'd2: begin
            mul_a = $signed({2'b0, pg_q[31:0]});
            mul_b = $signed({17'b0, mag_q[48:32]});
          end
          default: begin
            mul_a = $signed({18'b0, pg_q[47:32]});
            mul_b = $signed({17'b0, mag_q[48:32]});
          end
        endcase
      end
      ST_SC_WR: begin
        scr_we    = 1'b1;
        scr_wdata = score;
      end
      ST_EX_T1: begin
        mul_a = $signed({1'b0, t_q});
        mul_b = $signed({2'b0, x_q[31:0]});
      end
      ST_EX_T2: begin
        mul_a = $signed({2'b0, mul_q[63:32]});
        mul_b = $signed({2'b0, recip_q32(tn_q)});
      end
      ST_EX_WR: begin
        scr_we    = 1'b1;
        scr_wdata = e_val;
      end
      ST_N1_GO: div_req.start = 1'b1;
      ST_N1_WR: scr_we = 1'b1;
      ST_N2_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = tot2_q;
      end
      ST_N2_OUT: out_load = !out_valid_q || !out_stall_i;
      default: begin
      end
    endcase
  end

  // Parameter writes come straight from an accepted load beat. Entries past
  // the memory depth can never be read, so they are dropped.
  assign prm_we         = load_acc && ({1'b0, cluster_index_i} < MAX_NC);
  assign prm_waddr      = cluster_index_i[AW-1:0];
  assign prm_wdata.lead = lead_new;
  assign prm_wdata.ginv = gamma_sq_inv_i;
  assign prm_wdata.mu   = mu_i;
  assign prm_wdata.musq = mu_sq_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      nc_q        <= NC_W'(64);
      np_q        <= 32'd65536;
      stick_q     <= '0;
      h_q         <= '0;
      pp_q        <= '0;
      kb_q        <= '0;
      tn_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          CFG_NUM_CLUSTERS:    nc_q <= cfg_wdata_i[NC_W-1:0];
          CFG_NOISE_PRECISION: np_q <= cfg_wdata_i;
        endcase
      end
      if (load_acc) begin
        stick_q <= stick_new;
      end
      // Cluster counter: each pass walks entries zero through n-1, and the
      // write of entry h lands before entry h+1 is read.
      if (samp_acc) begin
        h_q <= '0;
      end else if ((st_q == ST_SC_WR) || (st_q == ST_EX_WR) || (st_q == ST_N1_WR) ||
                   (st_q == ST_N2_OUT && out_load)) begin
        h_q <= h_end ? '0 : h_q + AW'(1);
      end
      if (st_q == ST_SC_MAG) begin
        pp_q <= '0;
      end else if (st_q == ST_SC_PP) begin
        pp_q <= pp_q + 2'd1;
      end
      if (st_q == ST_EX_DX) begin
        kb_q <= 3'd5;
      end else if (st_q == ST_EX_K && kb_q != 3'd0) begin
        kb_q <= kb_q - 3'd1;
      end
      if (st_q == ST_EX_K) begin
        tn_q <= 4'd1;
      end else if (st_q == ST_EX_T3) begin
        tn_q <= tn_q + 4'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (samp_acc) begin
      s_q   <= sample_i;
      ssq_q <= sample_sq_i;
    end
    unique case (st_q)
      ST_SC_MU:  prm_q <= prm_rdata;
      ST_SC_PG:  d_q <= d_new;
      ST_SC_MAG: begin
        pg_q  <= mul_q[63:16];
        mag_q <= d_q[49] ? 49'(-d_q) : d_q[48:0];
        acc_q <= '0;
      end
      ST_SC_PP:  if (pp_q != 2'd0) acc_q <= acc_q + pp_add;
      ST_SC_ACC: acc_q <= acc_q + pp_add;
      ST_SC_WR:  if (h_q == '0 || score > mx_q) mx_q <= score;
      ST_EX_DX: begin
        x_q <= {dx[31:0], 16'b0};
        k_q <= '0;
        z_q <= 1'b0;
      end
      ST_EX_K: begin
        if (kb_q == 3'd5) begin
          z_q <= k_ge;
        end else if (k_ge) begin
          x_q        <= x_q - ln2_sh;
          k_q[kb_q]  <= 1'b1;
        end
        t_q   <= 33'h1_0000_0000;
        sum_q <= 36'sh1_0000_0000;
      end
      ST_EX_T2:  v_q <= mul_q[63:32];
      ST_EX_T3: begin
        t_q   <= {1'b0, tq};
        sum_q <= tn_q[0] ? sum_q - $signed({4'b0, tq}) : sum_q + $signed({4'b0, tq});
      end
      ST_EX_WR: begin
        // An all-zero exponential sum divides as one.
        if (h_end && tot_new == '0) begin
          tot_q <= SUM_W'(1);
        end else begin
          tot_q <= tot_new;
        end
        tot2_q <= '0;
      end
      ST_N1_WT,
      ST_N2_WT:  if (div_rsp.done) p_q <= (div_rsp.quo == '0) ? 32'd1 : div_rsp.quo;
      ST_N1_WR:  tot2_q <= tot2_new;
      default: begin
      end
    endcase
    if (samp_acc) begin
      tot_q <= '0;
    end
    if (out_load) begin
      out_cluster_q <= 6'(h_q);
      out_prob_q    <= p_q;
      out_last_q    <= h_end;
    end
  end

  mrs_ram #(
    .W($bits(param_t)),
    .D(MAX_CLUSTERS)
  ) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (prm_we),
    .waddr_i (prm_waddr),
    .wdata_i (prm_wdata),
    .raddr_i (prm_raddr),
    .rdata_o (prm_rdata)
  );

  mrs_ram #(
    .W(DATA_W),
    .D(MAX_CLUSTERS)
  ) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (h_q),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  mrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign result_cluster_o = out_cluster_q;
  assign probability_o    = out_prob_q;
  assign last_o           = out_last_q;

endmodule
